// ----- src/tcw_pkg.sv -----
// tcw_pkg: shared types and constants for the text console writer
// used by tcw_controller, tcw_datapath and text_console_writer_core
`timescale 1ns / 1ps

package tcw_pkg;

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // newline bytes
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  // text color cycle
  localparam logic [3:0] COLOR_FIRST = 4'd9;
  localparam logic [3:0] COLOR_LAST  = 4'hF;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;   // write zero to both stores at the sweep pointer
    logic put;          // perform a put transfer
    logic read_issue;   // launch the cell read for a read transfer
    logic load_read;    // capture the read data as the result
    logic load_put;     // present a put result
    logic sweep_step;   // one step of the scroll copy
    logic load_scroll;  // present the result of a scrolling put
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic op_read;      // requested operation is a read
    logic newline;      // requested byte is a newline
    logic col_last;     // cursor sits in the last column
    logic row_last;     // cursor sits on the last row
    logic sweep_last;   // sweep pointer at the last cell
  } status_t;

endpackage

// ----- src/tcw_ram.sv -----
// tcw_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tcw_controller.sv -----
// tcw_controller: sequencing state machine of the text console writer
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t   cmd,
  output logic            busy
);

  typedef enum logic [4:0] {
    ST_CLEAR      = 5'b00001,
    ST_IDLE       = 5'b00010,
    ST_READ       = 5'b00100,
    ST_SCROLL     = 5'b01000,
    ST_SCROLL_END = 5'b10000
  } state_t;

  state_t state, state_next;

  // state register, clearing pass runs after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (status.op_read) begin
            cmd.read_issue = 1'b1;
            state_next     = ST_READ;
          end else begin
            cmd.put = 1'b1;
            if ((status.newline || status.col_last) && status.row_last) begin
              state_next = ST_SCROLL;
            end else begin
              cmd.load_put = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        cmd.load_read = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_SCROLL: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: begin
        cmd.load_scroll = 1'b1;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- src/tcw_datapath.sv -----
// tcw_datapath: cell stores, cursor, color and result registers of the console
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::cmd_t    cmd,
  output tcw_pkg::status_t status,
  input  logic             operation,
  input  logic [7:0]       character,
  input  logic [6:0]       read_column,
  input  logic [4:0]       read_row,
  output logic             done,
  output logic [7:0]       read_character,
  output logic [3:0]       read_color,
  output logic [6:0]       cursor_column,
  output logic [4:0]       cursor_row,
  output logic [3:0]       text_color,
  output logic             scrolled
);

  localparam int CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int CXW     = $clog2(SCREEN_COLUMNS);
  localparam int CYW     = $clog2(SCREEN_ROWS);
  localparam int SRC_END = CELLS - SCREEN_COLUMNS;

  logic [CXW-1:0] cursor_x;
  logic [CYW-1:0] cursor_y;
  logic [3:0]     color;
  logic [AW-1:0]  sweep;
  logic           pipe_valid;
  logic [AW-1:0]  pipe_addr;
  logic           pipe_zero;
  logic           rd_in_range;
  logic [7:0]     result_char;
  logic [3:0]     result_color;
  logic           result_scrolled;
  logic           result_done;

  logic           newline;
  logic           wrap;
  logic [3:0]     color_adv;
  logic [AW-1:0]  put_addr;
  logic [AW-1:0]  rd_addr;
  logic           in_range_now;
  logic           char_we;
  logic [AW-1:0]  char_waddr;
  logic [7:0]     char_wdata;
  logic [AW-1:0]  char_raddr;
  logic [7:0]     char_rdata;
  logic           color_we;
  logic [AW-1:0]  color_waddr;
  logic [3:0]     color_wdata;
  logic [3:0]     color_rdata;
  logic [CXW+6:0] cx_ext;
  logic [CYW+4:0] cy_ext;

  // decode of the offered item and cursor position
  assign newline   = (character == tcw_pkg::CHAR_LF) || (character == tcw_pkg::CHAR_CR);
  assign wrap      = newline || status.col_last;
  assign color_adv = (color >= tcw_pkg::COLOR_FIRST && color < tcw_pkg::COLOR_LAST) ?
                     color + 4'd1 : tcw_pkg::COLOR_FIRST;

  assign status.op_read    = (operation == tcw_pkg::OP_READ);
  assign status.newline    = newline;
  assign status.col_last   = (cursor_x == CXW'(SCREEN_COLUMNS - 1));
  assign status.row_last   = (cursor_y == CYW'(SCREEN_ROWS - 1));
  assign status.sweep_last = (sweep == AW'(CELLS - 1));

  // cell addresses
  assign put_addr     = AW'(cursor_y) * AW'(SCREEN_COLUMNS) + AW'(cursor_x);
  assign rd_addr      = AW'(read_row) * AW'(SCREEN_COLUMNS) + AW'(read_column);
  assign in_range_now = (9'(read_column) < 9'(SCREEN_COLUMNS)) &&
                        (7'(read_row) < 7'(SCREEN_ROWS));

  // character store port selection: scroll copy, clearing, then put
  always_comb begin
    char_we    = 1'b0;
    char_waddr = put_addr;
    char_wdata = character;
    if (pipe_valid) begin
      char_we    = 1'b1;
      char_waddr = pipe_addr;
      char_wdata = pipe_zero ? 8'd0 : char_rdata;
    end else if (cmd.clear_step) begin
      char_we    = 1'b1;
      char_waddr = sweep;
      char_wdata = 8'd0;
    end else if (cmd.put && !newline) begin
      char_we = 1'b1;
    end
  end
  assign char_raddr = cmd.sweep_step ? sweep + AW'(SCREEN_COLUMNS) : rd_addr;

  // color store port selection: clearing, then put
  always_comb begin
    color_we    = 1'b0;
    color_waddr = put_addr;
    color_wdata = color;
    if (cmd.clear_step) begin
      color_we    = 1'b1;
      color_waddr = sweep;
      color_wdata = 4'd0;
    end else if (cmd.put && !newline) begin
      color_we = 1'b1;
    end
  end

  tcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_waddr),
    .wdata (char_wdata),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  tcw_ram #(.WIDTH(4), .DEPTH(CELLS)) u_color_ram (
    .clk   (clk),
    .we    (color_we),
    .waddr (color_waddr),
    .wdata (color_wdata),
    .raddr (rd_addr),
    .rdata (color_rdata)
  );

  // sweep pointer and scroll write stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      pipe_valid <= 1'b0;
    end else begin
      if (cmd.clear_step || cmd.sweep_step) begin
        sweep <= status.sweep_last ? '0 : sweep + AW'(1);
      end
      pipe_valid <= cmd.sweep_step;
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr <= sweep;
    pipe_zero <= (sweep >= AW'(SRC_END));
  end

  // cursor and text color
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      color    <= tcw_pkg::COLOR_FIRST;
    end else if (cmd.put) begin
      if (wrap) begin
        cursor_x <= '0;
        color    <= color_adv;
        if (!status.row_last) begin
          cursor_y <= cursor_y + CYW'(1);
        end
      end else begin
        cursor_x <= cursor_x + CXW'(1);
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.read_issue) begin
      rd_in_range <= in_range_now;
    end
    if (cmd.load_read) begin
      result_char     <= rd_in_range ? char_rdata : 8'd0;
      result_color    <= rd_in_range ? color_rdata : 4'd0;
      result_scrolled <= 1'b0;
    end else if (cmd.load_put || cmd.load_scroll) begin
      result_char     <= 8'd0;
      result_color    <= 4'd0;
      result_scrolled <= cmd.load_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_done <= 1'b0;
    end else begin
      result_done <= cmd.load_read || cmd.load_put || cmd.load_scroll;
    end
  end

  // outputs
  assign cx_ext         = (CXW + 7)'(cursor_x);
  assign cy_ext         = (CYW + 5)'(cursor_y);
  assign done           = result_done;
  assign read_character = result_char;
  assign read_color     = result_color;
  assign cursor_column  = cx_ext[6:0];
  assign cursor_row     = cy_ext[4:0];
  assign text_color     = color;
  assign scrolled       = result_scrolled;

endmodule

// ----- src/text_console_writer_core.sv -----
// text_console_writer_core: top level of the text console writer
// depends on tcw_pkg, tcw_controller, tcw_datapath (and tcw_ram below it)
`timescale 1ns / 1ps

// A transfer is taken when start is high and busy is low. Each transfer
// gives one result, shown for a single cycle with done high; the receiver
// cannot stall it, so capture it on that cycle. Cursor and color ports show
// the state after the latest transfer. A plain put leaves busy low and its
// result appears the next cycle. A read passes through ST_READ with busy
// high, as the cell stores have a registered read. A put that wraps (a
// newline, or a character in the last column) on the last row scrolls: the
// character store is copied one cell per cycle through its single write
// port while busy holds. After reset a clearing pass zeroes both stores
// with busy high.

module text_console_writer_core #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [7:0] character,
  input  logic [6:0] read_column,
  input  logic [4:0] read_row,
  output logic       done,
  output logic [7:0] read_character,
  output logic [3:0] read_color,
  output logic [6:0] cursor_column,
  output logic [4:0] cursor_row,
  output logic [3:0] text_color,
  output logic       scrolled
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  // sequencing
  tcw_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // stores, cursor and results
  tcw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (operation),
    .character      (character),
    .read_column    (read_column),
    .read_row       (read_row),
    .done           (done),
    .read_character (read_character),
    .read_color     (read_color),
    .cursor_column  (cursor_column),
    .cursor_row     (cursor_row),
    .text_color     (text_color),
    .scrolled       (scrolled)
  );

endmodule
